// ===== sv/wpl_pkg.sv =====
// Shared types and constants of the weighted pooling layer.
package wpl_pkg;

    // fixed-point widths (Q4.12 samples, Q8.24 products)
    localparam int PIX_W   = 16;
    localparam int PROD_W  = 32;
    localparam int PART_W  = 40;
    localparam int FRAC_W  = 12;
    localparam int Q_W     = PART_W - FRAC_W;

    // port widths
    localparam int CMD_W      = 1;
    localparam int COEF_CH_W  = 4;
    localparam int OUT_CH_W   = 4;
    localparam int OUT_POS_W  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_DIM_W  = 7;
    localparam int CFG_CH_W   = 5;

    // front/back decoupling queue
    localparam int QUEUE_DEPTH = 4;

    localparam logic signed [PIX_W-1:0] PIX_MAX = 16'sh7FFF;
    localparam logic signed [PIX_W-1:0] PIX_MIN = 16'sh8000;

    localparam logic [CFG_DIM_W-1:0] RST_WIDTH    = 7'd28;
    localparam logic [CFG_DIM_W-1:0] RST_HEIGHT   = 7'd28;
    localparam logic [CFG_CH_W-1:0]  RST_CHANNELS = 5'd6;

    typedef enum logic [CMD_W-1:0] {
        CMD_PIXEL = 1'b0,
        CMD_COEF  = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_MODE = 2'd0,
        CFG_WIDTH     = 2'd1,
        CFG_HEIGHT    = 2'd2,
        CFG_CHANNELS  = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        POOL_AVG = 1'b0,
        POOL_MAX = 1'b1
    } t_pool_mode;

    // per-pixel classification handed from front to back
    typedef struct packed {
        logic win_first;   // first pixel of its window
        logic win_done;    // last pixel of its window
        logic frame_end;   // window is the last of the frame
    } t_flags;

endpackage

// ===== sv/wpl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wpl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/wpl_queue.sv =====
// Small FIFO that decouples the front classifier from the pooling back end.
module wpl_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CNTW-1:0]  r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (32'(r_wr) == DEPTH - 1) ? '0 : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (32'(r_rd) == DEPTH - 1) ? '0 : r_rd + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNTW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_full  = (32'(r_cnt) == DEPTH);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

endmodule

// ===== sv/wpl_front.sv =====
// Front end: config registers, coefficient table, position tracking, pixel weighting.
module wpl_front #(
    parameter int MAX_WIDTH    = 64,
    parameter int MAX_HEIGHT   = 64,
    parameter int MAX_CHANNELS = 16,
    parameter int KERNEL_W     = 2,
    parameter int KERNEL_H     = 2,
    parameter int OP_W         = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [wpl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wpl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input words
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [wpl_pkg::CMD_W-1:0]      i_command,
    input  logic signed [15:0]             i_pixel,
    input  logic [wpl_pkg::COEF_CH_W-1:0]  i_coef_channel,
    input  logic signed [15:0]             i_coef_weight,
    input  logic signed [15:0]             i_coef_bias,
    // to queue
    output logic                           o_push,
    output logic [OP_W-1:0]                o_push_data,
    input  logic                           i_q_full,
    output logic                           o_pool_mode
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int DW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int NCW  = $clog2(MAX_CHANNELS + 1);
    localparam int CHW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PDX  = (MAX_WIDTH + KERNEL_W - 1) / KERNEL_W;
    localparam int PDY  = (MAX_HEIGHT + KERNEL_H - 1) / KERNEL_H;
    localparam int WXW  = (PDX > 1) ? $clog2(PDX) : 1;
    localparam int WYW  = (PDY > 1) ? $clog2(PDY) : 1;
    localparam int KXW  = (KERNEL_W > 1) ? $clog2(KERNEL_W) : 1;
    localparam int KYW  = (KERNEL_H > 1) ? $clog2(KERNEL_H) : 1;
    localparam int COEF_W = 2 * wpl_pkg::PIX_W;

    typedef struct packed {
        logic signed [wpl_pkg::PROD_W-1:0] product;
        logic signed [wpl_pkg::PIX_W-1:0]  bias;
        wpl_pkg::t_flags                   flags;
        logic [CHW-1:0]                    ch;
        logic [WYW-1:0]                    wy;
        logic [WXW-1:0]                    wx;
    } t_op;

    typedef struct packed {
        logic signed [wpl_pkg::PIX_W-1:0] pixel;
        wpl_pkg::t_flags                  flags;
        logic [CHW-1:0]                   ch;
        logic [WYW-1:0]                   wy;
        logic [WXW-1:0]                   wx;
    } t_stage;

    // config registers
    logic                            r_mode;
    logic [wpl_pkg::CFG_DIM_W-1:0]   r_cfg_w;
    logic [wpl_pkg::CFG_DIM_W-1:0]   r_cfg_h;
    logic [wpl_pkg::CFG_CH_W-1:0]    r_cfg_c;

    // position counters
    logic [CW-1:0]  r_col, n_col;
    logic [KXW-1:0] r_kx,  n_kx;
    logic [WXW-1:0] r_wx,  n_wx;
    logic [RW-1:0]  r_row, n_row;
    logic [KYW-1:0] r_ky,  n_ky;
    logic [WYW-1:0] r_wy,  n_wy;
    logic [CHW-1:0] r_ch,  n_ch;

    // weighting stage
    logic          r_a_valid;
    t_stage        r_a;
    logic          r_a_cvld;
    logic [MAX_CHANNELS-1:0] r_coef_vld;

    logic [DW-1:0]  lim_w;
    logic [HW-1:0]  lim_h;
    logic [NCW-1:0] lim_c;
    logic [CW-1:0]  col_base;
    logic [RW-1:0]  row_base;
    logic           accept, px_accept, coef_accept, coef_in_range;
    logic           col_ok, row_ok, in_window;
    logic           col_wrap, row_wrap, kx_wrap, ky_wrap;
    wpl_pkg::t_flags cls;
    logic [COEF_W-1:0] coef_rd;
    logic signed [wpl_pkg::PIX_W-1:0] weight, bias;
    t_op            op;

    // clamped frame dimensions
    always_comb begin
        if (r_cfg_w == '0) begin
            lim_w = DW'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            lim_w = DW'(MAX_WIDTH);
        end else begin
            lim_w = DW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            lim_h = HW'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            lim_h = HW'(MAX_HEIGHT);
        end else begin
            lim_h = HW'(r_cfg_h);
        end
        if (r_cfg_c == '0) begin
            lim_c = NCW'(1);
        end else if (32'(r_cfg_c) > MAX_CHANNELS) begin
            lim_c = NCW'(MAX_CHANNELS);
        end else begin
            lim_c = NCW'(r_cfg_c);
        end
    end

    assign o_in_ready    = !r_a_valid || !i_q_full;
    assign accept        = i_in_valid && o_in_ready;
    assign px_accept     = accept && (wpl_pkg::t_cmd'(i_command) == wpl_pkg::CMD_PIXEL);
    assign coef_accept   = accept && (wpl_pkg::t_cmd'(i_command) == wpl_pkg::CMD_COEF);
    assign coef_in_range = 32'(i_coef_channel) < MAX_CHANNELS;

    // window classification of the pixel at the current position
    assign col_base  = r_col - CW'(r_kx);
    assign row_base  = r_row - RW'(r_ky);
    assign col_ok    = (32'(col_base) + KERNEL_W) <= 32'(lim_w);
    assign row_ok    = (32'(row_base) + KERNEL_H) <= 32'(lim_h);
    assign in_window = col_ok && row_ok;
    assign kx_wrap   = (r_kx == KXW'(KERNEL_W - 1));
    assign ky_wrap   = (r_ky == KYW'(KERNEL_H - 1));
    assign col_wrap  = (32'(r_col) + 1) >= 32'(lim_w);
    assign row_wrap  = (32'(r_row) + 1) >= 32'(lim_h);

    always_comb begin
        cls.win_first = (r_kx == '0) && (r_ky == '0);
        cls.win_done  = kx_wrap && ky_wrap;
        cls.frame_end = ((32'(col_base) + 2 * KERNEL_W) > 32'(lim_w))
                     && ((32'(row_base) + 2 * KERNEL_H) > 32'(lim_h))
                     && (32'(r_ch) == 32'(lim_c) - 1);
    end

    // raster advance: column, then row, then channel
    always_comb begin
        n_col = r_col + CW'(1);
        n_kx  = kx_wrap ? '0 : r_kx + KXW'(1);
        n_wx  = kx_wrap ? r_wx + WXW'(1) : r_wx;
        n_row = r_row;
        n_ky  = r_ky;
        n_wy  = r_wy;
        n_ch  = r_ch;
        if (col_wrap) begin
            n_col = '0;
            n_kx  = '0;
            n_wx  = '0;
            n_row = r_row + RW'(1);
            n_ky  = ky_wrap ? '0 : r_ky + KYW'(1);
            n_wy  = ky_wrap ? r_wy + WYW'(1) : r_wy;
            if (row_wrap) begin
                n_row = '0;
                n_ky  = '0;
                n_wy  = '0;
                n_ch  = (32'(r_ch) == 32'(lim_c) - 1) ? '0 : r_ch + CHW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= wpl_pkg::POOL_AVG;
            r_cfg_w <= wpl_pkg::RST_WIDTH;
            r_cfg_h <= wpl_pkg::RST_HEIGHT;
            r_cfg_c <= wpl_pkg::RST_CHANNELS;
        end else if (i_cfg_we) begin
            unique case (wpl_pkg::t_cfg_idx'(i_cfg_idx))
                wpl_pkg::CFG_POOL_MODE: r_mode  <= i_cfg_data[0];
                wpl_pkg::CFG_WIDTH:     r_cfg_w <= i_cfg_data[wpl_pkg::CFG_DIM_W-1:0];
                wpl_pkg::CFG_HEIGHT:    r_cfg_h <= i_cfg_data[wpl_pkg::CFG_DIM_W-1:0];
                wpl_pkg::CFG_CHANNELS:  r_cfg_c <= i_cfg_data[wpl_pkg::CFG_CH_W-1:0];
            endcase
        end
    end

    // any config write restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_col <= '0;
            r_kx  <= '0;
            r_wx  <= '0;
            r_row <= '0;
            r_ky  <= '0;
            r_wy  <= '0;
            r_ch  <= '0;
        end else if (px_accept) begin
            r_col <= n_col;
            r_kx  <= n_kx;
            r_wx  <= n_wx;
            r_row <= n_row;
            r_ky  <= n_ky;
            r_wy  <= n_wy;
            r_ch  <= n_ch;
        end
    end

    // coefficient valid bits: an unloaded channel reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_vld <= '0;
        end else if (coef_accept && coef_in_range) begin
            r_coef_vld[CHW'(i_coef_channel)] <= 1'b1;
        end
    end

    wpl_ram #(
        .WIDTH (COEF_W),
        .DEPTH (MAX_CHANNELS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_accept && coef_in_range),
        .i_waddr (CHW'(i_coef_channel)),
        .i_wdata ({i_coef_weight, i_coef_bias}),
        .i_re    (px_accept),
        .i_raddr (r_ch),
        .o_rdata (coef_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_a_valid <= px_accept && in_window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (px_accept) begin
            r_a.pixel <= i_pixel;
            r_a.flags <= cls;
            r_a.ch    <= r_ch;
            r_a.wy    <= r_wy;
            r_a.wx    <= r_wx;
            r_a_cvld  <= r_coef_vld[r_ch];
        end
    end

    assign weight = r_a_cvld ? coef_rd[COEF_W-1:wpl_pkg::PIX_W] : '0;
    assign bias   = r_a_cvld ? coef_rd[wpl_pkg::PIX_W-1:0] : '0;

    // 16x16 product, registered by the queue storage
    always_comb begin
        op.product = r_a.pixel * weight;
        op.bias    = bias;
        op.flags   = r_a.flags;
        op.ch      = r_a.ch;
        op.wy      = r_a.wy;
        op.wx      = r_a.wx;
    end

    assign o_push      = r_a_valid && !i_q_full;
    assign o_push_data = op;
    assign o_pool_mode = r_mode;

endmodule

// ===== sv/wpl_back.sv =====
// Back end: window accumulate/max over column partials, scaling, bias and saturation.
module wpl_back #(
    parameter int MAX_WIDTH    = 64,
    parameter int MAX_HEIGHT   = 64,
    parameter int MAX_CHANNELS = 16,
    parameter int KERNEL_W     = 2,
    parameter int KERNEL_H     = 2,
    parameter int OP_W         = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [OP_W-1:0]               i_q_data,
    input  logic                          i_q_empty,
    output logic                          o_pop,
    input  logic                          i_pool_mode,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [15:0]            o_pooled_value,
    output logic [wpl_pkg::OUT_CH_W-1:0]  o_out_channel,
    output logic [wpl_pkg::OUT_POS_W-1:0] o_out_col,
    output logic [wpl_pkg::OUT_POS_W-1:0] o_out_row,
    output logic                          o_frame_last
);

    localparam int CHW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PDX  = (MAX_WIDTH + KERNEL_W - 1) / KERNEL_W;
    localparam int PDY  = (MAX_HEIGHT + KERNEL_H - 1) / KERNEL_H;
    localparam int WXW  = (PDX > 1) ? $clog2(PDX) : 1;
    localparam int WYW  = (PDY > 1) ? $clog2(PDY) : 1;
    localparam int QW   = wpl_pkg::Q_W;
    localparam int PTW  = wpl_pkg::PART_W;
    localparam int SUMW = QW + 2;
    localparam int MULW = 2 * QW + 1;
    // floor(q / KK) as a reciprocal multiply on the magnitude
    localparam int KK    = KERNEL_W * KERNEL_H;
    localparam int LK    = (KK > 1) ? $clog2(KK) : 0;
    localparam int DIV_S = QW + LK;
    localparam logic [63:0] DIV_M = ((64'd1 << DIV_S) + 64'(KK) - 64'd1) / 64'(KK);

    typedef struct packed {
        logic signed [wpl_pkg::PROD_W-1:0] product;
        logic signed [wpl_pkg::PIX_W-1:0]  bias;
        wpl_pkg::t_flags                   flags;
        logic [CHW-1:0]                    ch;
        logic [WYW-1:0]                    wy;
        logic [WXW-1:0]                    wx;
    } t_op;

    typedef struct packed {
        logic signed [wpl_pkg::PIX_W-1:0] bias;
        logic                             mode;
        logic                             last;
        logic [CHW-1:0]                   ch;
        logic [WYW-1:0]                   wy;
        logic [WXW-1:0]                   wx;
    } t_res;

    t_op  head;
    logic en;

    logic                  r_b2_valid;
    t_op                   r_b2;
    logic                  r_fwd_hit;
    logic signed [PTW-1:0] r_fwd_data;
    logic signed [PTW-1:0] part_rd, old_part, prod_ext, new_part;

    logic                  r_b3_valid;
    t_res                  r_b3;
    logic signed [QW-1:0]  r_b3_q;
    logic [QW:0]           mag_w;
    logic [MULW-1:0]       mul;

    logic                  r_b4_valid;
    t_res                  r_b4;
    logic signed [QW-1:0]  r_b4_q;
    logic [MULW-1:0]       r_b4_mul;
    logic [QW-1:0]         quot;
    logic signed [QW:0]    avg, pooled;
    logic signed [SUMW-1:0] sum;
    logic signed [wpl_pkg::PIX_W-1:0] sat;

    logic                  r_out_valid;
    t_res                  r_out;
    logic signed [wpl_pkg::PIX_W-1:0] r_out_value;

    assign head  = i_q_data;
    // whole back end moves together; only a held result stalls it
    assign en    = !r_out_valid || i_out_ready;
    assign o_pop = en && !i_q_empty;

    // column partials: read as the op leaves the queue, written back once it is held in r_b2
    wpl_ram #(
        .WIDTH (PTW),
        .DEPTH (PDX)
    ) u_part_ram (
        .i_clk   (i_clk),
        .i_we    (en && r_b2_valid),
        .i_waddr (r_b2.wx),
        .i_wdata (new_part),
        .i_re    (en),
        .i_raddr (head.wx),
        .o_rdata (part_rd)
    );

    always_comb begin
        old_part = r_fwd_hit ? r_fwd_data : part_rd;
        prod_ext = {{(PTW - wpl_pkg::PROD_W){r_b2.product[wpl_pkg::PROD_W-1]}}, r_b2.product};
        if (r_b2.flags.win_first) begin
            new_part = prod_ext;
        end else if (wpl_pkg::t_pool_mode'(i_pool_mode) == wpl_pkg::POOL_MAX) begin
            new_part = (prod_ext > old_part) ? prod_ext : old_part;
        end else begin
            new_part = old_part + prod_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b2_valid  <= 1'b0;
            r_b3_valid  <= 1'b0;
            r_b4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_b2_valid  <= o_pop;
            r_b3_valid  <= r_b2_valid && r_b2.flags.win_done;
            r_b4_valid  <= r_b3_valid;
            r_out_valid <= r_b4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b2       <= head;
            // back-to-back ops on one column see the value being written now
            r_fwd_hit  <= r_b2_valid && (r_b2.wx == head.wx);
            r_fwd_data <= new_part;
            r_b3.bias  <= r_b2.bias;
            r_b3.mode  <= i_pool_mode;
            r_b3.last  <= r_b2.flags.frame_end;
            r_b3.ch    <= r_b2.ch;
            r_b3.wy    <= r_b2.wy;
            r_b3.wx    <= r_b2.wx;
            r_b3_q     <= new_part[PTW-1:wpl_pkg::FRAC_W];
            r_b4       <= r_b3;
            r_b4_q     <= r_b3_q;
            r_b4_mul   <= mul;
            r_out      <= r_b4;
            r_out_value <= sat;
        end
    end

    // magnitude for a floored divide: negative q uses (-q + KK - 1)
    always_comb begin
        if (r_b3_q[QW-1]) begin
            mag_w = (QW + 1)'(KK - 1) - {r_b3_q[QW-1], r_b3_q};
        end else begin
            mag_w = {1'b0, r_b3_q};
        end
        mul = mag_w[QW-1:0] * DIV_M[QW:0];
    end

    always_comb begin
        quot = QW'(r_b4_mul >> DIV_S);
        avg  = r_b4_q[QW-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
        if (wpl_pkg::t_pool_mode'(r_b4.mode) == wpl_pkg::POOL_MAX) begin
            pooled = {r_b4_q[QW-1], r_b4_q};
        end else begin
            pooled = avg;
        end
        sum = {pooled[QW], pooled}
            + {{(SUMW - wpl_pkg::PIX_W){r_b4.bias[wpl_pkg::PIX_W-1]}}, r_b4.bias};
        // saturate when the bits above the 16-bit range disagree with the sign
        if (sum[SUMW-1:wpl_pkg::PIX_W-1] == '0 || sum[SUMW-1:wpl_pkg::PIX_W-1] == '1) begin
            sat = sum[wpl_pkg::PIX_W-1:0];
        end else if (sum[SUMW-1]) begin
            sat = wpl_pkg::PIX_MIN;
        end else begin
            sat = wpl_pkg::PIX_MAX;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pooled_value = r_out_value;
    assign o_out_channel  = wpl_pkg::OUT_CH_W'(r_out.ch);
    assign o_out_col      = wpl_pkg::OUT_POS_W'(r_out.wx);
    assign o_out_row      = wpl_pkg::OUT_POS_W'(r_out.wy);
    assign o_frame_last   = r_out.last;

endmodule

// ===== sv/weighted_pooling_layer_core.sv =====
// Top level of the weighted pooling layer: front end, queue and back end.
// Throughput: one word per cycle, pixels and coefficient loads alike, unless a weighted
// pixel waits on a full queue; the column-partial RAM read-modify-write is forwarded so
// a window column can be hit every cycle.
// Reset (synchronous, active low) restores the config defaults, zeroes the coefficient
// table through per-channel valid bits and empties every stage; no clearing pass runs.
module weighted_pooling_layer_core #(
    parameter int MAX_WIDTH    = 64,
    parameter int MAX_HEIGHT   = 64,
    parameter int MAX_CHANNELS = 16,
    parameter int KERNEL_W     = 2,
    parameter int KERNEL_H     = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [wpl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wpl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input words
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [wpl_pkg::CMD_W-1:0]      i_command,
    input  logic signed [15:0]             i_pixel,
    input  logic [wpl_pkg::COEF_CH_W-1:0]  i_coef_channel,
    input  logic signed [15:0]             i_coef_weight,
    input  logic signed [15:0]             i_coef_bias,
    // result words
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [15:0]             o_pooled_value,
    output logic [wpl_pkg::OUT_CH_W-1:0]   o_out_channel,
    output logic [wpl_pkg::OUT_POS_W-1:0]  o_out_col,
    output logic [wpl_pkg::OUT_POS_W-1:0]  o_out_row,
    output logic                           o_frame_last
);

    // queue word: product, bias, flags, channel, window row, window column
    localparam int CHW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PDX  = (MAX_WIDTH + KERNEL_W - 1) / KERNEL_W;
    localparam int PDY  = (MAX_HEIGHT + KERNEL_H - 1) / KERNEL_H;
    localparam int WXW  = (PDX > 1) ? $clog2(PDX) : 1;
    localparam int WYW  = (PDY > 1) ? $clog2(PDY) : 1;
    localparam int OP_W = wpl_pkg::PROD_W + wpl_pkg::PIX_W + $bits(wpl_pkg::t_flags)
                        + CHW + WYW + WXW;

    logic            push, pop, q_full, q_empty, pool_mode;
    logic [OP_W-1:0] push_data, head_data;

    // Front: takes every word. Coefficient loads go straight into the per-channel
    // table; pixels are placed in the raster (column, row, channel), classified
    // against the window grid, and pixels inside a complete window are weighted
    // (one 16x16 multiply) and pushed. Edge pixels only move the counters.
    wpl_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS),
        .KERNEL_W     (KERNEL_W),
        .KERNEL_H     (KERNEL_H),
        .OP_W         (OP_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_pixel        (i_pixel),
        .i_coef_channel (i_coef_channel),
        .i_coef_weight  (i_coef_weight),
        .i_coef_bias    (i_coef_bias),
        .o_push         (push),
        .o_push_data    (push_data),
        .i_q_full       (q_full),
        .o_pool_mode    (pool_mode)
    );

    // Short queue so a stalled result consumer does not immediately stall the input.
    wpl_queue #(
        .WIDTH (OP_W),
        .DEPTH (wpl_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (head_data),
        .o_empty (q_empty)
    );

    // Back: one partial per window column, updated with sum or max; a finished
    // window is scaled (shift for max, floored divide for average), biased,
    // saturated and held in the output register.
    wpl_back #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS),
        .KERNEL_W     (KERNEL_W),
        .KERNEL_H     (KERNEL_H),
        .OP_W         (OP_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_data       (head_data),
        .i_q_empty      (q_empty),
        .o_pop          (pop),
        .i_pool_mode    (pool_mode),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pooled_value (o_pooled_value),
        .o_out_channel  (o_out_channel),
        .o_out_col      (o_out_col),
        .o_out_row      (o_out_row),
        .o_frame_last   (o_frame_last)
    );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for weighted_pooling_layer_core: directed and random word streams.
module tb_top;

    // geometry of the block under test; the instance gets the same values
    localparam int IMG_MAX_W = 64;
    localparam int IMG_MAX_H = 64;
    localparam int CH_MAX    = 16;
    localparam int KW        = 2;
    localparam int KH        = 2;
    localparam int COL_SLOTS = (IMG_MAX_W + KW - 1) / KW;
    // average divides the Q8.24 window sum by KW*KH*4096: a floor shift
    localparam int AVG_SH    = wpl_pkg::FRAC_W + $clog2(KW * KH);
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_REPORTS   = 10;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle;

    // one finished window as the block reports it
    typedef struct packed {
        logic signed [15:0]            value;
        logic [wpl_pkg::OUT_CH_W-1:0]  chan;
        logic [wpl_pkg::OUT_POS_W-1:0] col;
        logic [wpl_pkg::OUT_POS_W-1:0] row;
        logic                          last;
    } t_window;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [wpl_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [wpl_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic [wpl_pkg::CMD_W-1:0]      i_command;
    logic signed [15:0]             i_pixel;
    logic [wpl_pkg::COEF_CH_W-1:0]  i_coef_channel;
    logic signed [15:0]             i_coef_weight;
    logic signed [15:0]             i_coef_bias;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic signed [15:0]             o_pooled_value;
    logic [wpl_pkg::OUT_CH_W-1:0]   o_out_channel;
    logic [wpl_pkg::OUT_POS_W-1:0]  o_out_col;
    logic [wpl_pkg::OUT_POS_W-1:0]  o_out_row;
    logic                           o_frame_last;

    // mirror of the layer: registers, coefficient table, column partials, scan position
    wpl_pkg::t_pool_mode lay_mode;
    int                  lay_width;
    int                  lay_height;
    int                  lay_chans;
    logic signed [15:0]  chan_weight [CH_MAX];
    logic signed [15:0]  chan_bias   [CH_MAX];
    longint              col_partial [COL_SLOTS];
    int                  pos_col;
    int                  pos_row;
    int                  pos_chan;

    t_window pending_windows[$];   // windows closed by accepted pixels, oldest first
    int      bad_windows;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_left;            // long receiver hold-off, counted down per cycle

    weighted_pooling_layer_core #(
        .MAX_WIDTH   (IMG_MAX_W),
        .MAX_HEIGHT  (IMG_MAX_H),
        .MAX_CHANNELS(CH_MAX),
        .KERNEL_W    (KW),
        .KERNEL_H    (KH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_pixel       (i_pixel),
        .i_coef_channel(i_coef_channel),
        .i_coef_weight (i_coef_weight),
        .i_coef_bias   (i_coef_bias),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pooled_value(o_pooled_value),
        .o_out_channel (o_out_channel),
        .o_out_col     (o_out_col),
        .o_out_row     (o_out_row),
        .o_frame_last  (o_frame_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // out-of-range dimensions: zero acts as one, anything above the maximum as the maximum
    function automatic int fit_dim(input int v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // 16-bit value leaning on the extremes now and then
    function automatic logic [15:0] pick16();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    // Applies one accepted word to the mirror. A coefficient word updates the table;
    // a pixel word is weighted, folded into its column partial and, on the window's
    // last pixel, turns into a pending window result.
    task automatic pool_word(input wpl_pkg::t_cmd cmd, input logic signed [15:0] pix,
                             input logic [3:0] cch, input logic signed [15:0] cw,
                             input logic signed [15:0] cb);
        int      w, h, nch, ow, oh, wx, kx, ky, wy;
        longint  prod, v;
        t_window res;
        if (cmd == wpl_pkg::CMD_COEF) begin
            chan_weight[cch] = cw;
            chan_bias[cch]   = cb;
        end else begin
            w   = fit_dim(lay_width, IMG_MAX_W);
            h   = fit_dim(lay_height, IMG_MAX_H);
            nch = fit_dim(lay_chans, CH_MAX);
            ow  = w / KW;
            oh  = h / KH;
            // edge columns/rows outside the last full window only move the scan on
            if (pos_col < ow * KW && pos_row < oh * KH && pos_chan < nch) begin
                wx   = pos_col / KW;
                kx   = pos_col % KW;
                ky   = pos_row % KH;
                prod = longint'(pix) * longint'(chan_weight[pos_chan]);
                if (kx == 0 && ky == 0)
                    col_partial[wx] = prod;
                else if (lay_mode == wpl_pkg::POOL_MAX) begin
                    if (prod > col_partial[wx])
                        col_partial[wx] = prod;
                end else
                    col_partial[wx] += prod;
                if (kx == KW - 1 && ky == KH - 1) begin
                    wy = pos_row / KH;
                    // arithmetic shift of a signed longint rounds toward minus infinity
                    if (lay_mode == wpl_pkg::POOL_MAX)
                        v = col_partial[wx] >>> wpl_pkg::FRAC_W;
                    else
                        v = col_partial[wx] >>> AVG_SH;
                    v += chan_bias[pos_chan];
                    if (v > 32767)
                        v = 32767;
                    if (v < -32768)
                        v = -32768;
                    res.value = v[15:0];
                    res.chan  = pos_chan[wpl_pkg::OUT_CH_W-1:0];
                    res.col   = wx[wpl_pkg::OUT_POS_W-1:0];
                    res.row   = wy[wpl_pkg::OUT_POS_W-1:0];
                    res.last  = (pos_chan == nch - 1 && wy == oh - 1 && wx == ow - 1);
                    pending_windows.push_back(res);
                end
            end
            pos_col++;
            if (pos_col >= w) begin
                pos_col = 0;
                pos_row++;
                if (pos_row >= h) begin
                    pos_row = 0;
                    pos_chan++;
                    if (pos_chan >= nch)
                        pos_chan = 0;
                end
            end
        end
    endtask

    // Offers one word. Called at a falling edge, returns at a falling edge after the
    // word went in; valid is left high so the next call can keep it up without a gap.
    task automatic send_word(input wpl_pkg::t_cmd cmd, input logic signed [15:0] pix,
                             input logic [3:0] cch, input logic signed [15:0] cw,
                             input logic signed [15:0] cb);
        int gap;
        gap = 0;
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_pixel        <= pix;
        i_coef_channel <= cch;
        i_coef_weight  <= cw;
        i_coef_bias    <= cb;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        pool_word(cmd, pix, cch, cw, cb);
        @(negedge i_clk);
    endtask

    task automatic send_pixel(input logic signed [15:0] pix);
        send_word(wpl_pkg::CMD_PIXEL, pix, 4'(pick16()), pick16(), pick16());
    endtask

    task automatic send_coef(input logic [3:0] cch, input logic signed [15:0] cw,
                             input logic signed [15:0] cb);
        send_word(wpl_pkg::CMD_COEF, pick16(), cch, cw, cb);
    endtask

    // mostly pixels; now and then a coefficient reload of any channel
    task automatic send_random_word();
        if ($urandom_range(0, 99) < 8)
            send_coef(4'($urandom), pick16(), pick16());
        else
            send_pixel(pick16());
    endtask

    // stop offering and wait until every pending window came out, plus pipeline slack
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_windows.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // writes all four registers on back-to-back cycles once the block is idle;
    // each write also restarts the frame scan
    task automatic set_layer(input int mode, input int w, input int h, input int c);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= wpl_pkg::CFG_POOL_MODE;
        i_cfg_data <= wpl_pkg::CFG_DATA_W'(mode & 1);
        @(negedge i_clk);
        i_cfg_idx  <= wpl_pkg::CFG_WIDTH;
        i_cfg_data <= wpl_pkg::CFG_DATA_W'(w);
        @(negedge i_clk);
        i_cfg_idx  <= wpl_pkg::CFG_HEIGHT;
        i_cfg_data <= wpl_pkg::CFG_DATA_W'(h);
        @(negedge i_clk);
        i_cfg_idx  <= wpl_pkg::CFG_CHANNELS;
        i_cfg_data <= wpl_pkg::CFG_DATA_W'(c);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        lay_mode   = wpl_pkg::t_pool_mode'(mode & 1);
        lay_width  = w & 127;
        lay_height = h & 127;
        lay_chans  = c & 31;
        pos_col    = 0;
        pos_row    = 0;
        pos_chan   = 0;
    endtask

    task automatic set_idling(input t_idle mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 86; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default:   begin send_idle_pct = 21; recv_stall_pct = 21; end
        endcase
    endtask

    // one configured stretch: load the live channels, then a random word stream
    task automatic run_layer(input int mode, input int w, input int h, input int c,
                             input t_idle idle, input int words);
        int nch;
        set_layer(mode, w, h, c);
        set_idling(idle);
        nch = fit_dim(c & 31, CH_MAX);
        for (int k = 0; k < nch; k++)
            send_coef(4'(k), pick16(), pick16());
        repeat (words) send_random_word();
    endtask

    // coefficient table must read as zero right after reset: every window gives 0
    task automatic test_table_reset();
        set_layer(wpl_pkg::POOL_AVG, 2, 2, 2);
        set_idling(IDLE_NONE);
        repeat (8) send_pixel(pick16());
    endtask

    // full-scale products in both modes, saturation at both rails, floor on negatives
    task automatic test_saturation();
        send_coef(4'd0, 16'sh8000, 16'sh7FFF);
        send_coef(4'd1, 16'sh7FFF, 16'sh8000);
        repeat (4) send_pixel(16'sh8000);        // sum 2^32 -> clips high
        repeat (4) send_pixel(16'sh8000);        // large negative -> clips low
        set_layer(wpl_pkg::POOL_MAX, 2, 2, 2);
        send_pixel(16'sh0001);
        send_pixel(16'shFFFF);
        send_pixel(16'sh7FFF);
        send_pixel(16'sh0000);
        send_pixel(16'sh0001);                   // small positive product (32767)
        send_pixel(16'sh8000);
        send_pixel(16'sh7FFF);
        send_pixel(16'shFFFF);
    endtask

    // odd sizes, out-of-range registers, images smaller than the kernel
    task automatic test_shapes();
        run_layer(wpl_pkg::POOL_MAX, 3, 5, 3, IDLE_SEND, 100);     // edge column and row dropped
        run_layer(wpl_pkg::POOL_AVG, 0, 2, 1, IDLE_RECV, 40);      // width 0 acts as 1
        run_layer(wpl_pkg::POOL_MAX, 100, 2, 0, IDLE_BOTH, 150);   // 64 wide, one channel
        run_layer(wpl_pkg::POOL_AVG, 64, 64, 31, IDLE_NONE, 150);  // largest frame
        run_layer(wpl_pkg::POOL_MAX, 2, 127, 16, IDLE_RECV, 100);
        run_layer(wpl_pkg::POOL_AVG, 1, 1, 1, IDLE_NONE, 20);
    endtask

    // small random layers so frames wrap often; stretches often end mid-window
    task automatic test_random_layers();
        for (int k = 0; k < 4; k++)
            run_layer($urandom_range(0, 1), $urandom_range(1, 12), $urandom_range(1, 8),
                      $urandom_range(1, 4), t_idle'(k), $urandom_range(50, 80));
    endtask

    // receiver holds off long enough for the block to fill and stall its input;
    // afterwards the sender pauses until all windows are out, then resumes
    task automatic test_backpressure();
        set_layer(wpl_pkg::POOL_AVG, 8, 4, 2);
        set_idling(IDLE_NONE);
        send_coef(4'd0, pick16(), pick16());
        send_coef(4'd1, pick16(), pick16());
        hold_left = 300;
        repeat (200) send_pixel(pick16());
        drain_results();
        set_idling(IDLE_BOTH);
        repeat (50) send_random_word();
    endtask

    // receiver side: random stalls, or a long counted hold-off when requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // every accepted result word is checked against the oldest pending window
    always @(posedge i_clk) begin
        t_window got;
        t_window want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            got.value = o_pooled_value;
            got.chan  = o_out_channel;
            got.col   = o_out_col;
            got.row   = o_out_row;
            got.last  = o_frame_last;
            if (pending_windows.size() == 0) begin
                bad_windows++;
                if (bad_windows <= MAX_REPORTS)
                    $display("unexpected result word: val %0d ch %0d col %0d row %0d last %0b",
                             got.value, got.chan, got.col, got.row, got.last);
            end else begin
                want = pending_windows.pop_front();
                if (got.value !== want.value || got.chan !== want.chan ||
                    got.col !== want.col || got.row !== want.row || got.last !== want.last) begin
                    bad_windows++;
                    if (bad_windows <= MAX_REPORTS)
                        $display("window differs: got val %0d ch %0d col %0d row %0d last %0b, %s",
                                 got.value, got.chan, got.col, got.row, got.last,
                                 $sformatf("want val %0d ch %0d col %0d row %0d last %0b",
                                           want.value, want.chan, want.col, want.row,
                                           want.last));
                end
            end
        end
    end

    // hard stop in case the block hangs
    initial begin
        #3_000_000;
        $display("weighted_pooling_layer_core: mismatch");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = wpl_pkg::CFG_POOL_MODE;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_command      = wpl_pkg::CMD_PIXEL;
        i_pixel        = '0;
        i_coef_channel = '0;
        i_coef_weight  = '0;
        i_coef_bias    = '0;
        i_out_ready    = 1'b0;
        bad_windows    = 0;
        hold_left      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        lay_mode       = wpl_pkg::POOL_AVG;
        lay_width      = int'(wpl_pkg::RST_WIDTH);
        lay_height     = int'(wpl_pkg::RST_HEIGHT);
        lay_chans      = int'(wpl_pkg::RST_CHANNELS);
        pos_col        = 0;
        pos_row        = 0;
        pos_chan       = 0;
        for (int k = 0; k < CH_MAX; k++) begin
            chan_weight[k] = '0;
            chan_bias[k]   = '0;
        end
        for (int k = 0; k < COL_SLOTS; k++)
            col_partial[k] = 0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_table_reset();
        test_saturation();
        test_shapes();
        test_random_layers();
        test_backpressure();

        drain_results();
        if (bad_windows == 0 && pending_windows.size() == 0)
            $display("weighted_pooling_layer_core: match");
        else
            $display("weighted_pooling_layer_core: mismatch");
        $finish;
    end

endmodule
